[hw/rtl/jtlb_pkg.sv]
// Package for the joint TLB: sizes, command codes, payload and entry types,
// and the control/status structs shared by the controller and the datapath.
// Depends on nothing.
`default_nettype none

package jtlb_pkg;

  localparam int ENTRY_COUNT = 32;
  localparam int IDX_W       = $clog2(ENTRY_COUNT);
  localparam int CNT_W       = IDX_W + 1;

  localparam int CMD_W   = 2;
  localparam int INDEX_W = 5;
  localparam int PMASK_W = 25;
  localparam int WORD_W  = 32;
  localparam int PHYS_W  = 29;
  localparam int MASK_W  = 12;

  localparam logic [CMD_W-1:0] CMD_WRITE     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ      = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PROBE     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TRANSLATE = 2'd3;

  localparam logic [WORD_W-1:0] KSEG_LO    = 32'h8000_0000;
  localparam logic [WORD_W-1:0] KSEG_HI    = 32'hBFFF_FFFF;
  localparam logic [WORD_W-1:0] PHYS_LIMIT = 32'h1FFF_FFFF;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [INDEX_W-1:0] index;
    logic [PMASK_W-1:0] page_mask;
    logic [WORD_W-1:0]  entry_hi;
    logic [WORD_W-1:0]  entry_lo0;
    logic [WORD_W-1:0]  entry_lo1;
    logic [WORD_W-1:0]  vaddr;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] probe_index;
    logic               probe_miss;
    logic [PMASK_W-1:0] read_page_mask;
    logic [WORD_W-1:0]  read_entry_hi;
    logic [WORD_W-1:0]  read_entry_lo0;
    logic [WORD_W-1:0]  read_entry_lo1;
    logic [PHYS_W-1:0]  phys_addr;
    logic               translate_hit;
    logic               address_defined;
  } out_item_t;

  // One TLB entry as it sits in the entry RAM.
  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic [WORD_W-1:0] hi;
    logic [WORD_W-1:0] lo0;
    logic [WORD_W-1:0] lo1;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic write;
    logic scan_step;
    logic out_load;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_last;
    logic pipe_empty;
  } dp_status_t;

  function automatic logic in_kseg(input logic [WORD_W-1:0] a);
    return (a >= KSEG_LO) && (a <= KSEG_HI);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/jtlb_ifs.sv]
// Valid/ready channel interfaces for the joint TLB command and result items.
// Depends on jtlb_pkg.
`default_nettype none

interface jtlb_in_if import jtlb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [INDEX_W-1:0] index;
  logic [PMASK_W-1:0] page_mask;
  logic [WORD_W-1:0]  entry_hi;
  logic [WORD_W-1:0]  entry_lo0;
  logic [WORD_W-1:0]  entry_lo1;
  logic [WORD_W-1:0]  vaddr;

  modport source (output valid, command, index, page_mask, entry_hi, entry_lo0,
                  entry_lo1, vaddr, input ready);
  modport sink (input valid, command, index, page_mask, entry_hi, entry_lo0,
                entry_lo1, vaddr, output ready);
endinterface

interface jtlb_out_if import jtlb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] probe_index;
  logic               probe_miss;
  logic [PMASK_W-1:0] read_page_mask;
  logic [WORD_W-1:0]  read_entry_hi;
  logic [WORD_W-1:0]  read_entry_lo0;
  logic [WORD_W-1:0]  read_entry_lo1;
  logic [PHYS_W-1:0]  phys_addr;
  logic               translate_hit;
  logic               address_defined;

  modport source (output valid, probe_index, probe_miss, read_page_mask,
                  read_entry_hi, read_entry_lo0, read_entry_lo1, phys_addr,
                  translate_hit, address_defined, input ready);
  modport sink (input valid, probe_index, probe_miss, read_page_mask,
                read_entry_hi, read_entry_lo0, read_entry_lo1, phys_addr,
                translate_hit, address_defined, output ready);
endinterface

`default_nettype wire

[hw/rtl/jtlb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module jtlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/jtlb_ctrl.sv]
// Command sequencer of the joint TLB: accepts one command, steps the
// datapath through write, read or scan, and owns the result valid flag.
// Depends on jtlb_pkg.
`default_nettype none

module jtlb_ctrl import jtlb_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [CMD_W-1:0] in_command,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output ctrl_cmd_t             cmd,
  input  wire dp_status_t       status
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WRITE  = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (in_command)
            CMD_WRITE: state_nxt = S_WRITE;
            CMD_READ:  state_nxt = S_READ;
            default:   state_nxt = S_SCAN;
          endcase
        end
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = S_FINISH;
      end
      S_READ: begin
        state_nxt = S_FINISH;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (status.pipe_empty) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[hw/rtl/jtlb_dp.sv]
// Datapath of the joint TLB: entry RAM with defined bits, scan counter,
// probe matcher, two-stage page checker and the result register.
// Depends on jtlb_pkg and jtlb_ram.
`default_nettype none

module jtlb_dp import jtlb_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_item,
  input  wire ctrl_cmd_t cmd,
  output dp_status_t     status,
  output out_item_t      out_item
);

  in_item_t               in_r;
  logic                   idx_ok_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [CNT_W-1:0]       p1_r;
  logic                   v1_r;
  logic [IDX_W-1:0]       addr_q_r;
  logic [ENTRY_COUNT-1:0] defined_r;

  // Page check stage A registers.
  logic              a_valid_r;
  logic [WORD_W-1:0] a_vs_r;
  logic [WORD_W-1:0] a_span_r;
  logic              a_v_r;
  logic              a_psok_r;
  logic [PHYS_W-1:0] a_ps_r;
  logic              a_def_r;

  // Accumulators.
  logic               pr_found_r;
  logic [INDEX_W-1:0] pr_idx_r;
  logic               tr_hit_r;
  logic               tr_def_r;
  logic [PHYS_W-1:0]  tr_phys_r;

  out_item_t out_r, out_nxt;

  logic               is_probe, is_trans;
  logic [IDX_W-1:0]   idx_addr, raddr;
  logic [ENTRY_W-1:0] rdata, wdata;
  entry_t             ent;
  logic               ent_def;

  assign is_probe = (in_r.command == CMD_PROBE);
  assign is_trans = (in_r.command == CMD_TRANSLATE);
  assign idx_addr = IDX_W'(in_r.index);

  always_comb begin
    if (is_probe) begin
      raddr = cnt_r[IDX_W-1:0];
    end else if (is_trans) begin
      raddr = cnt_r[IDX_W:1];
    end else begin
      raddr = idx_addr;
    end
  end

  assign wdata = {in_r.page_mask[24:13], in_r.entry_hi, in_r.entry_lo0, in_r.entry_lo1};

  jtlb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRY_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.write && idx_ok_r),
    .waddr (idx_addr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // An entry never written reads as all zeros.
  assign ent_def = defined_r[addr_q_r];
  assign ent     = ent_def ? entry_t'(rdata) : '0;

  // Probe match on the entry presented this cycle.
  logic [WORD_W-1:0] pm_cmp;
  logic              pr_match;

  assign pm_cmp   = ~{7'b0, ent.mask, 13'b0} & 32'hFFFF_E000;
  assign pr_match = (((ent.hi ^ in_r.entry_hi) & pm_cmp) == '0) &&
                    (ent.hi[8] || (ent.hi[7:0] == in_r.entry_hi[7:0]));

  // Page check stage A: start of the page and its frame.
  logic              odd;
  logic [WORD_W-1:0] base, inc, vs_a, span_a, lo_a;
  logic [12:0]       mask_inc;

  assign odd      = p1_r[0];
  assign base     = {ent.hi[31:13], 13'b0};
  assign mask_inc = {1'b0, ent.mask} + 13'd1;
  assign inc      = {7'b0, mask_inc, 12'b0};
  assign vs_a     = odd ? base + inc : base;
  assign span_a   = {8'b0, ent.mask, 12'hFFF};
  assign lo_a     = odd ? ent.lo1 : ent.lo0;

  // Page check stage B: end of the page, usability and the offset sum.
  logic [WORD_W-1:0] ve_b, sum_b;
  logic              ok_b, inr_b, listed_b;

  assign ve_b  = a_vs_r + a_span_r;
  assign ok_b  = a_def_r && a_v_r && (ve_b > a_vs_r) && a_psok_r &&
                 !(a_vs_r[31] && (ve_b <= KSEG_HI));
  assign inr_b = (in_r.vaddr >= a_vs_r) && (in_r.vaddr <= ve_b);
  assign listed_b = a_def_r && (!a_v_r || ok_b);
  assign sum_b = in_r.vaddr - a_vs_r + {3'b0, a_ps_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      defined_r <= '0;
      v1_r      <= 1'b0;
      a_valid_r <= 1'b0;
    end else begin
      v1_r      <= cmd.scan_step;
      a_valid_r <= v1_r && is_trans;
      if (cmd.write && idx_ok_r) begin
        defined_r[idx_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_q_r <= raddr;
    p1_r     <= cnt_r;
    a_vs_r   <= vs_a;
    a_span_r <= span_a;
    a_v_r    <= lo_a[1];
    a_psok_r <= ({lo_a[25:6], 12'b0} <= PHYS_LIMIT);
    a_ps_r   <= {lo_a[22:6], 12'b0};
    a_def_r  <= ent_def;
    if (cmd.load) begin
      in_r       <= in_item;
      idx_ok_r   <= (32'(in_item.index) < 32'(ENTRY_COUNT));
      cnt_r      <= '0;
      pr_found_r <= 1'b0;
      pr_idx_r   <= '0;
      tr_hit_r   <= 1'b0;
      tr_def_r   <= 1'b0;
      tr_phys_r  <= '0;
    end else begin
      if (cmd.scan_step) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (v1_r && is_probe && pr_match && !pr_found_r) begin
        pr_found_r <= 1'b1;
        pr_idx_r   <= INDEX_W'(p1_r[IDX_W-1:0]);
      end
      if (a_valid_r && inr_b) begin
        if (listed_b) begin
          tr_def_r <= 1'b1;
        end
        if (ok_b && !tr_hit_r) begin
          tr_hit_r  <= 1'b1;
          tr_phys_r <= sum_b[PHYS_W-1:0];
        end
      end
    end
    if (cmd.out_load) begin
      out_r <= out_nxt;
    end
  end

  always_comb begin
    out_nxt = '0;
    unique case (in_r.command)
      CMD_WRITE: begin
        out_nxt = '0;
      end
      CMD_READ: begin
        if (idx_ok_r) begin
          out_nxt.read_page_mask = {ent.mask, 13'b0};
          out_nxt.read_entry_hi  = ent.hi & ~{7'b0, ent.mask, 13'b0};
          out_nxt.read_entry_lo0 = ent.lo0;
          out_nxt.read_entry_lo1 = ent.lo1;
        end
      end
      CMD_PROBE: begin
        out_nxt.probe_index = pr_idx_r;
        out_nxt.probe_miss  = !pr_found_r;
      end
      CMD_TRANSLATE: begin
        if (in_kseg(in_r.vaddr)) begin
          out_nxt.phys_addr       = in_r.vaddr[PHYS_W-1:0];
          out_nxt.translate_hit   = 1'b1;
          out_nxt.address_defined = 1'b1;
        end else begin
          out_nxt.phys_addr       = tr_phys_r;
          out_nxt.translate_hit   = tr_hit_r;
          out_nxt.address_defined = tr_def_r;
        end
      end
      default: out_nxt = '0;
    endcase
  end

  assign status.scan_last  = is_trans ? (cnt_r == CNT_W'(2 * ENTRY_COUNT - 1))
                                      : (cnt_r == CNT_W'(ENTRY_COUNT - 1));
  assign status.pipe_empty = !v1_r && !a_valid_r;
  assign out_item          = out_r;

endmodule

`default_nettype wire

[hw/rtl/joint_tlb_probe_read_write_translate_top.sv]
// Top level of the joint TLB: ties the command sequencer to the datapath
// and maps both onto the command and result channels.
// Depends on jtlb_pkg, jtlb_ifs, jtlb_ctrl, jtlb_dp and jtlb_ram.
//
//   Channel  Direction  Handshake      Carries
//   in_ch    sink       valid/ready    command, index, page_mask, entry_hi,
//                                      entry_lo0, entry_lo1, vaddr
//   out_ch   source     valid/ready    probe, read and translate result fields
//
// A write or a read passes its write or read state, then loads its result in
// the final state. A probe reads all 32 entries and a translation both pages
// of each, then drains its match or page check pipeline and loads in the final
// state. The next command transfers in the cycle after the load, whether
// or not the sink has taken the result. A stalled result holds the block in its
// final state. Reset is synchronous, active low, and clears the defined bits.
`default_nettype none

module joint_tlb_probe_read_write_translate_top import jtlb_pkg::*; (
  input wire logic  clk,
  input wire logic  rst_n,
  jtlb_in_if.sink   in_ch,
  jtlb_out_if.source out_ch
);

  in_item_t   in_item;
  out_item_t  out_item;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Gather the command fields into one item for the datapath.
  assign in_item.command   = in_ch.command;
  assign in_item.index     = in_ch.index;
  assign in_item.page_mask = in_ch.page_mask;
  assign in_item.entry_hi  = in_ch.entry_hi;
  assign in_item.entry_lo0 = in_ch.entry_lo0;
  assign in_item.entry_lo1 = in_ch.entry_lo1;
  assign in_item.vaddr     = in_ch.vaddr;

  // The sequencer decides when the command transfers and when the result
  // register loads; the datapath does the storage and the matching.
  jtlb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .cmd        (cmd),
    .status     (status)
  );

  jtlb_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .status   (status),
    .out_item (out_item)
  );

  // The result register drives the output channel directly.
  assign out_ch.probe_index     = out_item.probe_index;
  assign out_ch.probe_miss      = out_item.probe_miss;
  assign out_ch.read_page_mask  = out_item.read_page_mask;
  assign out_ch.read_entry_hi   = out_item.read_entry_hi;
  assign out_ch.read_entry_lo0  = out_item.read_entry_lo0;
  assign out_ch.read_entry_lo1  = out_item.read_entry_lo1;
  assign out_ch.phys_addr       = out_item.phys_addr;
  assign out_ch.translate_hit   = out_item.translate_hit;
  assign out_ch.address_defined = out_item.address_defined;

  // Only one command is worked on at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("command accepted while another was still in progress");

  // A probe miss always reports entry zero.
  a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.probe_miss |-> (out_ch.probe_index == '0))
    else $error("probe miss with a nonzero index");

  // A translated address always lies in a defined region.
  a_hit_defined: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.translate_hit |-> out_ch.address_defined)
    else $error("translate hit on an undefined address");

  // A new result is loaded only when the previous one has left.
  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("result register overwritten before transfer");

endmodule

`default_nettype wire
